[design/bdt_pkg.sv]
// Shared types, widths and codes of the decision tree evaluator.
package bdt_pkg;

	localparam int NODE_DEPTH = 1024;
	localparam int NODE_AW = 10;
	localparam int BIT_W = 6;
	localparam int FEAT_W = 64;
	localparam int LVL_W = 7;
	localparam int FC_W = 7;
	localparam int NODE_W = 2 + BIT_W + 2 * NODE_AW;
	localparam int IN_DATA_W = 104;
	localparam int OUT_DATA_W = 16;
	localparam int FEATURE_BITS_DEF = 64;
	localparam logic [FC_W-1:0] FC_RESET = 7'd64;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_BIT = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	typedef struct packed {
		logic is_leaf;
		logic value;
		logic [BIT_W-1:0] split_bit;
		logic [NODE_AW-1:0] zero_child;
		logic [NODE_AW-1:0] one_child;
	} node_t;

	// A queued command: a node write carries index and node word, an
	// evaluation carries the feature vector.
	typedef struct packed {
		logic cmd;
		logic [FEAT_W-1:0] payload;
	} qent_t;

	typedef struct packed {
		logic valid;
		qent_t entry;
	} qhead_t;

endpackage

[design/bdt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[design/bdt_front.sv]
// Input side: takes beats, sorts them into node writes and evaluations, queues them.
module bdt_front (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [bdt_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input logic s_axis_tuser,
	output bdt_pkg::qhead_t head,
	input logic pop
);
	import bdt_pkg::*;

	localparam int QD = 2;

	qent_t q_q [QD];
	logic wptr_q, rptr_q;
	logic [1:0] cnt_q;
	qent_t ent;
	logic push;

	always_comb begin
		ent.cmd = s_axis_tuser;
		if (s_axis_tuser == CMD_EVAL) begin
			ent.payload = s_axis_tdata[38 +: FEAT_W];
		end else begin
			ent.payload = '0;
			ent.payload[NODE_W +: NODE_AW] = s_axis_tdata[9:0];
			ent.payload[NODE_W-1:0] = {s_axis_tdata[10], s_axis_tdata[11],
				s_axis_tdata[17:12], s_axis_tdata[27:18], s_axis_tdata[37:28]};
		end
	end

	assign s_axis_tready = (cnt_q != 2'(QD));
	assign push = s_axis_tvalid && s_axis_tready;
	assign head.valid = (cnt_q != 2'd0);
	assign head.entry = q_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

[design/bdt_back.sv]
// Execution side: writes nodes into the table and walks the tree for evaluations.
module bdt_back #(
	parameter int FEATURE_BITS = bdt_pkg::FEATURE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [bdt_pkg::FC_W-1:0] feature_count,
	input bdt_pkg::qhead_t head,
	output logic pop,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [bdt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import bdt_pkg::*;

	typedef enum logic {IDLE, WALK} state_t;

	state_t state_q;
	logic [FEAT_W-1:0] feat_q;
	logic [LVL_W-1:0] levels_q;
	logic answer_q;
	logic [1:0] status_q;
	logic [LVL_W-1:0] out_levels_q;
	logic out_valid_q;

	logic ram_we, ram_re;
	logic [NODE_AW-1:0] ram_waddr, ram_raddr;
	logic [NODE_W-1:0] ram_rdata;
	node_t node;
	logic bad_bit, too_long, finish, out_free, is_eval;
	logic [NODE_AW-1:0] next_idx;

	bdt_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(head.entry.payload[NODE_W-1:0]),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		node = node_t'(ram_rdata);
		bad_bit = ({1'b0, node.split_bit} >= feature_count)
			|| ({1'b0, node.split_bit} >= FC_W'(FEATURE_BITS));
		// The walk gives up once FEATURE_BITS+1 nodes have been visited.
		too_long = (levels_q == LVL_W'(FEATURE_BITS));
		next_idx = feat_q[node.split_bit] ? node.one_child : node.zero_child;
		finish = (state_q == WALK) && (node.is_leaf || bad_bit || too_long);
		out_free = !out_valid_q || m_axis_tready;
		is_eval = (head.entry.cmd == CMD_EVAL);
		pop = (state_q == IDLE) && head.valid;
		ram_we = pop && !is_eval;
		ram_waddr = head.entry.payload[NODE_W +: NODE_AW];
		ram_re = (pop && is_eval) || ((state_q == WALK) && !finish);
		ram_raddr = (state_q == IDLE) ? '0 : next_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			feat_q <= '0;
			levels_q <= '0;
			answer_q <= 1'b0;
			status_q <= ST_OK;
			out_levels_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && !(finish && out_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (pop && is_eval) begin
						feat_q <= head.entry.payload;
						levels_q <= '0;
						state_q <= WALK;
					end
				end
				WALK: begin
					if (finish) begin
						// Hold the node read until the result register frees up.
						if (out_free) begin
							out_valid_q <= 1'b1;
							if (node.is_leaf) begin
								answer_q <= node.value;
								status_q <= ST_OK;
								out_levels_q <= levels_q;
							end else if (bad_bit) begin
								answer_q <= 1'b0;
								status_q <= ST_BAD_BIT;
								out_levels_q <= levels_q;
							end else begin
								answer_q <= 1'b0;
								status_q <= ST_TOO_LONG;
								out_levels_q <= levels_q + LVL_W'(1);
							end
							state_q <= IDLE;
						end
					end else begin
						levels_q <= levels_q + LVL_W'(1);
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {(OUT_DATA_W - 3 - LVL_W)'(0), out_levels_q, status_q, answer_q};
endmodule

[design/binary_decision_tree_evaluator_top.sv]
// Top level of the decision tree evaluator.
//
// Input beats on s_axis: tuser is the command (0 writes one node, 1 evaluates
// a feature vector). Node writes give no output beat; each evaluation gives
// exactly one beat on m_axis with the leaf value, a status code and the number
// of splits passed. The feature_count register is written through cfg_we and
// cfg_wdata; the user must do so only while the block is idle, which the block
// itself does not enforce. A two-entry queue sits between input and execution,
// so input beats keep being taken while a walk runs or a result waits. The node
// table is one RAM read per visited node; an evaluation visits at most
// FEATURE_BITS+1 nodes and holds the execution side until its walk ends, and a
// node write is a single table write. Reset empties the queue, drops any
// pending result and sets feature_count to 64; the node table keeps no reset
// value and must be written before it is walked. When m_axis_tready is low the
// result is held, the walk stops at its last node, and the queue fills before
// s_axis_tready drops.
module binary_decision_tree_evaluator_top #(
	parameter int FEATURE_BITS = bdt_pkg::FEATURE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [bdt_pkg::FC_W-1:0] cfg_wdata,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// node_index[9:0], node_is_leaf[10], leaf_value[11], split_bit[17:12],
	// zero_child[27:18], one_child[37:28], feature_bits[101:38], zeros above
	input logic [bdt_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input logic s_axis_tuser, // command
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// answer[0], status[2:1], levels_walked[9:3], zeros above
	output logic [bdt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import bdt_pkg::*;

	logic [FC_W-1:0] feature_count_q;
	qhead_t head;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feature_count_q <= FC_RESET;
		end else if (cfg_we) begin
			feature_count_q <= cfg_wdata;
		end
	end

	bdt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.head(head),
		.pop(pop)
	);

	bdt_back #(.FEATURE_BITS(FEATURE_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.feature_count(feature_count_q),
		.head(head),
		.pop(pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:1] != 2'd3))
		else $error("result carries an undefined status code");

	a_error_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[2:1] != ST_OK)) |-> !m_axis_tdata[0])
		else $error("failed walk returned a nonzero answer");

	a_too_long_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[2:1] == ST_TOO_LONG))
		|-> (m_axis_tdata[9:3] == LVL_W'(FEATURE_BITS + 1)))
		else $error("overlong walk reports a wrong level count");

	a_levels_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[2:1] != ST_TOO_LONG))
		|-> (m_axis_tdata[9:3] <= LVL_W'(FEATURE_BITS)))
		else $error("completed walk passed more splits than feature bits");
endmodule
